// ===== design/sld_pkg.sv =====
// Shared types, codes and helpers for the string literal decoder.
// Used by sld_core and string_literal_decoder_unit; no dependencies.
package sld_pkg;

    // Input operation codes
    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_CP    = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_UTF8     = 3'd1;
    localparam logic [2:0] ERR_END      = 3'd2;
    localparam logic [2:0] ERR_ESCAPE   = 3'd3;
    localparam logic [2:0] ERR_HEX      = 3'd4;
    localparam logic [2:0] ERR_NO_CLOSE = 3'd5;

    // Literal modes
    localparam logic MODE_STRING = 1'b0;
    localparam logic MODE_CHAR   = 1'b1;

    // Special bytes
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_UC_U   = 8'h55;

    // UTF-8 lead byte class limits and tag offsets
    localparam logic [7:0]  UTF_ASCII_LIM = 8'd128;
    localparam logic [7:0]  UTF_LEAD_LIM  = 8'd192;
    localparam logic [7:0]  UTF_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF_LEAD4     = 8'hF0;
    localparam logic [7:0]  UTF_LEAD_BAD  = 8'hF8;
    localparam logic [31:0] UTF_OFS2      = 32'h0000_3080;
    localparam logic [31:0] UTF_OFS3      = 32'h000E_2080;
    localparam logic [31:0] UTF_OFS4      = 32'h03C8_2080;

    // Hex digit counts
    localparam logic [3:0] HEX_U4   = 4'd4;
    localparam logic [3:0] HEX_U8   = 4'd8;
    localparam logic [3:0] HEX_XMAX = 4'd4;

    // Output queue depth (two results per item max)
    localparam int OUT_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_UTF  = 3'd2,
        PH_ESC  = 3'd3,
        PH_HEX  = 3'd4,
        PH_XHEX = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  lead;
        logic [1:0]  tails;
        logic [31:0] acc;
        logic [3:0]  hcount;
        logic [3:0]  htarget;
        logic        cdone;
    } st_t;

    localparam st_t ST_CLEAR = '{
        phase:   PH_IDLE,
        lead:    8'd0,
        tails:   2'd0,
        acc:     32'd0,
        hcount:  4'd0,
        htarget: 4'd0,
        cdone:   1'b0
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] code_point;
        logic [2:0]  error_code;
    } res_t;

    // Results of one accepted beat: count 0..2, in order
    typedef struct packed {
        logic [1:0] n;
        res_t       res0;
        res_t       res1;
    } step_out_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Decode one ASCII hex digit
    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            h.value = b[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== design/sld_core.sv =====
// Decoder state and per-beat step logic: one input beat in, up to two results out.
// Depends on sld_pkg.
module sld_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [1:0]          op,
    input  logic [7:0]          byte_req,
    input  logic                literal_mode,
    output sld_pkg::step_out_t  step
);

    sld_pkg::st_t st_reg, st_next;
    sld_pkg::hex_t hv;
    logic [31:0] acc_hex, acc_utf, fin_cp;
    logic [3:0]  hc_inc;
    logic [1:0]  tails_dec;
    logic        flush, fin, fail, close, idle, run;
    logic [2:0]  fail_code;
    sld_pkg::res_t res_a, res_b;
    logic          emit_b;

    // Compute next state and results for the accepted beat
    always_comb begin
        st_next   = st_reg;
        hv        = sld_pkg::hex_digit(byte_req);
        acc_hex   = {st_reg.acc[27:0], hv.value};
        acc_utf   = {st_reg.acc[25:0], 6'd0} + {24'd0, byte_req};
        hc_inc    = st_reg.hcount + 4'd1;
        tails_dec = st_reg.tails - 2'd1;
        flush     = 1'b0;
        fin       = 1'b0;
        fin_cp    = '0;
        fail      = 1'b0;
        fail_code = sld_pkg::ERR_NONE;
        close     = 1'b0;
        idle      = 1'b0;
        run       = 1'b0;
        res_a     = '0;
        res_b     = '0;
        emit_b    = 1'b0;

        if (accept) begin
            if (op == sld_pkg::OP_START) begin
                st_next       = sld_pkg::ST_CLEAR;
                st_next.phase = sld_pkg::PH_BODY;
            end else if ((op == sld_pkg::OP_DATA || op == sld_pkg::OP_END) &&
                         st_reg.phase != sld_pkg::PH_IDLE) begin
                run = 1'b1;
                // \x escape: take another digit, or flush the value and fall to body
                if (st_reg.phase == sld_pkg::PH_XHEX) begin
                    if (op == sld_pkg::OP_DATA && hv.ok) begin
                        run            = 1'b0;
                        st_next.acc    = acc_hex;
                        st_next.hcount = hc_inc;
                        if (hc_inc >= sld_pkg::HEX_XMAX) begin
                            fin    = 1'b1;
                            fin_cp = acc_hex;
                        end
                    end else begin
                        flush   = 1'b1;
                        res_a   = '{sld_pkg::KIND_CP, st_reg.acc, sld_pkg::ERR_NONE};
                        st_next = sld_pkg::ST_CLEAR;
                        st_next.phase = sld_pkg::PH_BODY;
                        st_next.cdone = st_reg.cdone | (literal_mode == sld_pkg::MODE_CHAR);
                    end
                end

                if (run) begin
                    case (st_next.phase)
                        sld_pkg::PH_BODY: begin
                            if (op == sld_pkg::OP_END) begin
                                fail      = 1'b1;
                                fail_code = (literal_mode == sld_pkg::MODE_CHAR) ?
                                            sld_pkg::ERR_END : sld_pkg::ERR_NO_CLOSE;
                            end else if (literal_mode == sld_pkg::MODE_CHAR && st_next.cdone) begin
                                if (byte_req == sld_pkg::CH_SQUOTE) begin
                                    close = 1'b1;
                                end else begin
                                    fail      = 1'b1;
                                    fail_code = sld_pkg::ERR_NO_CLOSE;
                                end
                            end else if (literal_mode == sld_pkg::MODE_STRING &&
                                         byte_req == sld_pkg::CH_DQUOTE) begin
                                close = 1'b1;
                            end else if (byte_req == sld_pkg::CH_BSLASH) begin
                                st_next.phase = sld_pkg::PH_ESC;
                            end else if (byte_req < sld_pkg::UTF_ASCII_LIM) begin
                                fin    = 1'b1;
                                fin_cp = {24'd0, byte_req};
                            end else if (byte_req < sld_pkg::UTF_LEAD_LIM) begin
                                fail      = 1'b1;
                                fail_code = sld_pkg::ERR_UTF8;
                            end else begin
                                st_next.lead  = byte_req;
                                st_next.acc   = {24'd0, byte_req};
                                st_next.tails = (byte_req < sld_pkg::UTF_LEAD3) ? 2'd1 :
                                                (byte_req < sld_pkg::UTF_LEAD4) ? 2'd2 : 2'd3;
                                st_next.phase = sld_pkg::PH_UTF;
                            end
                        end
                        sld_pkg::PH_UTF: begin
                            if (op == sld_pkg::OP_END || byte_req[7:6] != 2'b10) begin
                                fail      = 1'b1;
                                fail_code = (op == sld_pkg::OP_END) ?
                                            sld_pkg::ERR_END : sld_pkg::ERR_UTF8;
                            end else begin
                                st_next.acc   = acc_utf;
                                st_next.tails = tails_dec;
                                if (tails_dec == 2'd0) begin
                                    if (st_reg.lead < sld_pkg::UTF_LEAD3) begin
                                        fin    = 1'b1;
                                        fin_cp = acc_utf - sld_pkg::UTF_OFS2;
                                    end else if (st_reg.lead < sld_pkg::UTF_LEAD4) begin
                                        fin    = 1'b1;
                                        fin_cp = acc_utf - sld_pkg::UTF_OFS3;
                                    end else if (st_reg.lead < sld_pkg::UTF_LEAD_BAD) begin
                                        fin    = 1'b1;
                                        fin_cp = acc_utf - sld_pkg::UTF_OFS4;
                                    end else begin
                                        fail      = 1'b1;
                                        fail_code = sld_pkg::ERR_UTF8;
                                    end
                                end
                            end
                        end
                        sld_pkg::PH_ESC: begin
                            if (op == sld_pkg::OP_END) begin
                                fail      = 1'b1;
                                fail_code = sld_pkg::ERR_END;
                            end else begin
                                fin = 1'b1;
                                case (byte_req)
                                    sld_pkg::CH_BSLASH,
                                    sld_pkg::CH_SQUOTE,
                                    sld_pkg::CH_DQUOTE: fin_cp = {24'd0, byte_req};
                                    sld_pkg::CH_ZERO:   fin_cp = 32'd0;
                                    sld_pkg::CH_LC_A:   fin_cp = 32'd7;
                                    sld_pkg::CH_LC_B:   fin_cp = 32'd8;
                                    sld_pkg::CH_LC_T:   fin_cp = 32'd9;
                                    sld_pkg::CH_LC_N:   fin_cp = 32'd10;
                                    sld_pkg::CH_LC_V:   fin_cp = 32'd11;
                                    sld_pkg::CH_LC_F:   fin_cp = 32'd12;
                                    sld_pkg::CH_LC_R:   fin_cp = 32'd13;
                                    sld_pkg::CH_LC_U, sld_pkg::CH_UC_U: begin
                                        fin             = 1'b0;
                                        st_next.lead    = '0;
                                        st_next.tails   = '0;
                                        st_next.acc     = '0;
                                        st_next.hcount  = '0;
                                        st_next.htarget = (byte_req == sld_pkg::CH_LC_U) ?
                                                          sld_pkg::HEX_U4 : sld_pkg::HEX_U8;
                                        st_next.phase   = sld_pkg::PH_HEX;
                                    end
                                    sld_pkg::CH_LC_X: begin
                                        fin             = 1'b0;
                                        st_next.lead    = '0;
                                        st_next.tails   = '0;
                                        st_next.acc     = '0;
                                        st_next.hcount  = '0;
                                        st_next.htarget = '0;
                                        st_next.phase   = sld_pkg::PH_XHEX;
                                    end
                                    default: begin
                                        fin       = 1'b0;
                                        fail      = 1'b1;
                                        fail_code = sld_pkg::ERR_ESCAPE;
                                    end
                                endcase
                            end
                        end
                        sld_pkg::PH_HEX: begin
                            if (op == sld_pkg::OP_END || !hv.ok) begin
                                fail      = 1'b1;
                                fail_code = sld_pkg::ERR_HEX;
                            end else begin
                                st_next.acc    = acc_hex;
                                st_next.hcount = hc_inc;
                                if (hc_inc >= st_reg.htarget) begin
                                    fin    = 1'b1;
                                    fin_cp = acc_hex;
                                end
                            end
                        end
                        default: idle = 1'b1;
                    endcase
                end

                // Apply the outcome of the beat
                if (fin) begin
                    emit_b  = 1'b1;
                    res_b   = '{sld_pkg::KIND_CP, fin_cp, sld_pkg::ERR_NONE};
                    st_next.lead    = '0;
                    st_next.tails   = '0;
                    st_next.acc     = '0;
                    st_next.hcount  = '0;
                    st_next.htarget = '0;
                    st_next.phase   = sld_pkg::PH_BODY;
                    if (literal_mode == sld_pkg::MODE_CHAR) begin
                        st_next.cdone = 1'b1;
                    end
                end
                if (fail) begin
                    emit_b  = 1'b1;
                    res_b   = '{sld_pkg::KIND_ERR, 32'd0, fail_code};
                    st_next = sld_pkg::ST_CLEAR;
                end
                if (close) begin
                    emit_b  = 1'b1;
                    res_b   = '{sld_pkg::KIND_CLOSE, 32'd0, sld_pkg::ERR_NONE};
                    st_next = sld_pkg::ST_CLEAR;
                end
                if (idle) begin
                    st_next = sld_pkg::ST_CLEAR;
                end
            end
        end
    end

    // Pack the results in order: flushed \x value first
    always_comb begin
        if (flush) begin
            step.n    = emit_b ? 2'd2 : 2'd1;
            step.res0 = res_a;
            step.res1 = res_b;
        end else begin
            step.n    = emit_b ? 2'd1 : 2'd0;
            step.res0 = res_b;
            step.res1 = '0;
        end
    end

    // Hold decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= sld_pkg::ST_CLEAR;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== design/string_literal_decoder_unit.sv =====
// Top level of the string literal decoder: config register, decoder core, result queue.
// Depends on sld_pkg and sld_core.
// Result path: the results of an accepted input beat are registered into the result queue, and m_ shows the queue head.
// Throughput: one input beat per cycle while the queue has room for two results; a beat with
// two results (flushed \x value plus the next one) fills two queue entries.
// Reset (aresetn low, synchronous): decoder idle, literal_mode string, queue empty.
module string_literal_decoder_unit #(
    parameter int OUT_DEPTH = sld_pkg::OUT_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_byte_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_code_point,
    output logic [2:0]  m_error_code,
    output logic        m_last
);

    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        sld_pkg::res_t res;
        logic          last;
    } entry_t;

    logic               mode_reg;
    logic               accept, pop;
    sld_pkg::step_out_t step;
    entry_t             queue_reg [OUT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_p1, wr_p2;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   push_n;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= sld_pkg::MODE_STRING;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    // Accept input while the queue has room for two result beats
    assign s_ready = (cnt_reg <= CNT_W'(OUT_DEPTH - 2));
    assign accept  = s_valid && s_ready;

    sld_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .op           (s_op),
        .byte_req     (s_byte_req),
        .literal_mode (mode_reg),
        .step         (step)
    );

    // Queue pointer arithmetic
    always_comb begin
        wr_p1 = (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        wr_p2 = (wr_p1 == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_p1 + 1'b1;
        push_n = CNT_W'(step.n);
        pop    = m_valid && m_ready;

        case (step.n)
            2'd1:    wr_ptr_next = wr_p1;
            2'd2:    wr_ptr_next = wr_p2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase

        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end else begin
            rd_ptr_next = rd_ptr_reg;
        end

        cnt_next = cnt_reg + push_n - CNT_W'(pop);
    end

    // Advance queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Write result beats; the last one of the item carries last
    always_ff @(posedge aclk) begin
        if (step.n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= '{step.res0, step.n == 2'd1};
        end
        if (step.n == 2'd2) begin
            queue_reg[wr_p1] <= '{step.res1, 1'b1};
        end
    end

    // Drive the result channel from the queue head
    assign m_valid      = (cnt_reg != '0);
    assign m_kind       = queue_reg[rd_ptr_reg].res.kind;
    assign m_code_point = queue_reg[rd_ptr_reg].res.code_point;
    assign m_error_code = queue_reg[rd_ptr_reg].res.error_code;
    assign m_last       = queue_reg[rd_ptr_reg].last;

    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

    // A start beat produces no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == sld_pkg::OP_START) |=>
            cnt_reg == $past(cnt_reg) - CNT_W'($past(pop)))
        else $error("start beat produced a result");

    // Errors and closes end the results of their beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == sld_pkg::KIND_ERR || m_kind == sld_pkg::KIND_CLOSE)) |-> m_last)
        else $error("error or close beat not marked last");

    // Error code is set exactly on error beats
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_kind == sld_pkg::KIND_ERR) == (m_error_code != sld_pkg::ERR_NONE)))
        else $error("error code does not match kind");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for string_literal_decoder_unit: directed and random literals,
// both literal modes, random stalls on both channels. Depends on sld_pkg and the design.
module tb;

    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UC_A    = 8'h41;
    localparam logic [7:0] CH_UC_F    = 8'h46;
    localparam int         LIMIT_CYC  = 200000;
    localparam int         PHASE_ITEMS = 200;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] code_point;
        logic [2:0]  error_code;
        logic        last;
    } lit_beat_t;

    // Tracks the decoder state and the beats still owed on the result channel
    class literal_scoreboard;
        logic             mode;
        sld_pkg::phase_t  ph;
        logic [7:0]       lead;
        logic [1:0]       tails;
        logic [31:0]      acc;
        logic [3:0]       hcnt;
        logic [3:0]       htgt;
        logic             cdone;
        lit_beat_t        step_beats[$];
        lit_beat_t        awaited[$];
        int               mismatches;
        int               kind_seen[3];

        function new();
            mode = sld_pkg::MODE_STRING;
            go_idle();
            mismatches = 0;
            kind_seen = '{0, 0, 0};
        endfunction

        function void push_beat(logic [1:0] k, logic [31:0] cp, logic [2:0] e);
            lit_beat_t b;
            b.kind = k;
            b.code_point = cp;
            b.error_code = e;
            b.last = 1'b0;
            if (step_beats.size() < 2) step_beats.insert(step_beats.size(), b);
        endfunction

        function void clear_work();
            lead = '0;
            tails = '0;
            acc = '0;
            hcnt = '0;
            htgt = '0;
        endfunction

        function void go_idle();
            clear_work();
            cdone = 1'b0;
            ph = sld_pkg::PH_IDLE;
        endfunction

        function void fail(logic [2:0] e);
            push_beat(sld_pkg::KIND_ERR, 32'd0, e);
            go_idle();
        endfunction

        function void close_lit();
            push_beat(sld_pkg::KIND_CLOSE, 32'd0, sld_pkg::ERR_NONE);
            go_idle();
        endfunction

        function void emit_char(logic [31:0] cp);
            push_beat(sld_pkg::KIND_CP, cp, sld_pkg::ERR_NONE);
            clear_work();
            ph = sld_pkg::PH_BODY;
            if (mode == sld_pkg::MODE_CHAR) cdone = 1'b1;
        endfunction

        // Digit value, or 16 for a non-hex byte
        function logic [4:0] hex_of(logic [7:0] b);
            if (b >= sld_pkg::CH_ZERO && b <= CH_NINE) return 5'(b - sld_pkg::CH_ZERO);
            if (b >= sld_pkg::CH_LC_A && b <= sld_pkg::CH_LC_F)
                return 5'(b - sld_pkg::CH_LC_A + 8'd10);
            if (b >= CH_UC_A && b <= CH_UC_F) return 5'(b - CH_UC_A + 8'd10);
            return 5'd16;
        endfunction

        function void body_byte(logic [7:0] b);
            if (mode == sld_pkg::MODE_CHAR) begin
                if (cdone) begin
                    if (b == sld_pkg::CH_SQUOTE) close_lit();
                    else fail(sld_pkg::ERR_NO_CLOSE);
                    return;
                end
            end else if (b == sld_pkg::CH_DQUOTE) begin
                close_lit();
                return;
            end
            if (b == sld_pkg::CH_BSLASH) begin
                ph = sld_pkg::PH_ESC;
            end else if (b < sld_pkg::UTF_ASCII_LIM) begin
                emit_char({24'd0, b});
            end else if (b < sld_pkg::UTF_LEAD_LIM) begin
                fail(sld_pkg::ERR_UTF8);
            end else begin
                lead = b;
                acc = {24'd0, b};
                tails = (b < sld_pkg::UTF_LEAD3) ? 2'd1 :
                        ((b < sld_pkg::UTF_LEAD4) ? 2'd2 : 2'd3);
                ph = sld_pkg::PH_UTF;
            end
        endfunction

        function void utf_byte(logic [7:0] b);
            if (b[7:6] != 2'b10) begin
                fail(sld_pkg::ERR_UTF8);
                return;
            end
            acc = (acc << 6) + {24'd0, b};
            tails = tails - 2'd1;
            if (tails != 2'd0) return;
            if (lead < sld_pkg::UTF_LEAD3) emit_char(acc - sld_pkg::UTF_OFS2);
            else if (lead < sld_pkg::UTF_LEAD4) emit_char(acc - sld_pkg::UTF_OFS3);
            else if (lead < sld_pkg::UTF_LEAD_BAD) emit_char(acc - sld_pkg::UTF_OFS4);
            else fail(sld_pkg::ERR_UTF8);
        endfunction

        function void esc_byte(logic [7:0] b);
            case (b)
                sld_pkg::CH_BSLASH,
                sld_pkg::CH_SQUOTE,
                sld_pkg::CH_DQUOTE: emit_char({24'd0, b});
                sld_pkg::CH_ZERO: emit_char(32'd0);
                sld_pkg::CH_LC_A: emit_char(32'd7);
                sld_pkg::CH_LC_B: emit_char(32'd8);
                sld_pkg::CH_LC_T: emit_char(32'd9);
                sld_pkg::CH_LC_N: emit_char(32'd10);
                sld_pkg::CH_LC_V: emit_char(32'd11);
                sld_pkg::CH_LC_F: emit_char(32'd12);
                sld_pkg::CH_LC_R: emit_char(32'd13);
                sld_pkg::CH_LC_U: begin
                    clear_work();
                    htgt = sld_pkg::HEX_U4;
                    ph = sld_pkg::PH_HEX;
                end
                sld_pkg::CH_UC_U: begin
                    clear_work();
                    htgt = sld_pkg::HEX_U8;
                    ph = sld_pkg::PH_HEX;
                end
                sld_pkg::CH_LC_X: begin
                    clear_work();
                    ph = sld_pkg::PH_XHEX;
                end
                default: fail(sld_pkg::ERR_ESCAPE);
            endcase
        endfunction

        function void hex_byte(logic [7:0] b);
            logic [4:0] d;
            d = hex_of(b);
            if (d[4]) begin
                fail(sld_pkg::ERR_HEX);
                return;
            end
            acc = (acc << 4) | {28'd0, d[3:0]};
            hcnt = hcnt + 4'd1;
            if (hcnt >= htgt) emit_char(acc);
        endfunction

        // Advance the state by one accepted input beat and queue what it owes
        function void note_item(logic [1:0] op, logic [7:0] b);
            logic [4:0] d;
            logic [1:0] o;
            step_beats.delete();
            o = op;
            if (o == sld_pkg::OP_START) begin
                go_idle();
                ph = sld_pkg::PH_BODY;
            end else if ((o == sld_pkg::OP_DATA || o == sld_pkg::OP_END) &&
                         ph != sld_pkg::PH_IDLE) begin
                // a \x escape ends on the first non-hex byte or the fourth digit
                if (ph == sld_pkg::PH_XHEX) begin
                    d = hex_of(b);
                    if (o == sld_pkg::OP_DATA && !d[4]) begin
                        acc = (acc << 4) | {28'd0, d[3:0]};
                        hcnt = hcnt + 4'd1;
                        if (hcnt >= sld_pkg::HEX_XMAX) emit_char(acc);
                        o = OP_NONE;
                    end else begin
                        emit_char(acc);
                    end
                end
                if (o == sld_pkg::OP_DATA) begin
                    case (ph)
                        sld_pkg::PH_BODY: body_byte(b);
                        sld_pkg::PH_UTF:  utf_byte(b);
                        sld_pkg::PH_ESC:  esc_byte(b);
                        sld_pkg::PH_HEX:  hex_byte(b);
                        default: go_idle();
                    endcase
                end else if (o == sld_pkg::OP_END) begin
                    case (ph)
                        sld_pkg::PH_BODY: fail((mode == sld_pkg::MODE_CHAR) ?
                                               sld_pkg::ERR_END : sld_pkg::ERR_NO_CLOSE);
                        sld_pkg::PH_UTF,
                        sld_pkg::PH_ESC:  fail(sld_pkg::ERR_END);
                        sld_pkg::PH_HEX:  fail(sld_pkg::ERR_HEX);
                        default: go_idle();
                    endcase
                end
            end
            if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
            foreach (step_beats[i]) awaited.insert(awaited.size(), step_beats[i]);
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one result beat against the oldest one owed
        function void check_beat(logic [1:0] k, logic [31:0] cp, logic [2:0] e, logic l);
            lit_beat_t want;
            if (awaited.size() == 0) begin
                $display("%0t: extra result, expected none, actual kind %0d cp %0h err %0d",
                         $time, k, cp, e);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            report_field("kind", 32'(want.kind), 32'(k));
            report_field("code_point", want.code_point, cp);
            report_field("error_code", 32'(want.error_code), 32'(e));
            report_field("last", 32'(want.last), 32'(l));
            if (k < 2'd3) kind_seen[k]++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = sld_pkg::OP_DATA;
    logic [7:0]  s_byte_req = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [31:0] m_code_point;
    logic [2:0]  m_error_code;
    logic        m_last;

    literal_scoreboard sb = new();
    bit          idle_en = 1'b1;
    logic        cur_mode = sld_pkg::MODE_STRING;
    int          items_sent = 0;
    int          cycles = 0;
    int          stall_left = 0;
    logic [7:0]  esc_set[11] = '{sld_pkg::CH_BSLASH, sld_pkg::CH_SQUOTE, sld_pkg::CH_DQUOTE,
                                 sld_pkg::CH_ZERO, sld_pkg::CH_LC_A, sld_pkg::CH_LC_B,
                                 sld_pkg::CH_LC_F, sld_pkg::CH_LC_N, sld_pkg::CH_LC_T,
                                 sld_pkg::CH_LC_R, sld_pkg::CH_LC_V};

    string_literal_decoder_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_byte_req   (s_byte_req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_code_point (m_code_point),
        .m_error_code (m_error_code),
        .m_last       (m_last)
    );

    always #4 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYC) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Check results before noting inputs: a beat accepted now cannot answer this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_beat(m_kind, m_code_point, m_error_code, m_last);
            if (s_valid && s_ready) sb.note_item(s_op, s_byte_req);
            if (cfg_valid && cfg_ready) sb.mode = cfg_data;
        end
    end

    // Random result side back-pressure in bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Drive one input beat; called and returns at a falling edge
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_byte_req <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Hold input off until every owed result has come and the pipe is empty
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_mode(input logic m);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return sld_pkg::CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? sld_pkg::CH_LC_A : CH_UC_A) + 8'(v) - 8'd10;
    endfunction

    task automatic send_hex(input int n);
        for (int i = 0; i < n; i++)
            send_item(sld_pkg::OP_DATA, hex_char(4'($urandom_range(0, 15))));
    endtask

    task automatic send_tails(input int n);
        for (int i = 0; i < n; i++) send_item(sld_pkg::OP_DATA, 8'h80 | 8'($urandom_range(0, 63)));
    endtask

    // One well-formed character: raw ASCII, UTF-8 of 2 to 4 bytes, or an escape
    task automatic send_char();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            2: begin
                send_item(sld_pkg::OP_DATA, 8'($urandom_range(8'hC0, 8'hDF)));
                send_tails(1);
            end
            3: begin
                send_item(sld_pkg::OP_DATA, 8'($urandom_range(8'hE0, 8'hEF)));
                send_tails(2);
            end
            4: begin
                send_item(sld_pkg::OP_DATA, 8'($urandom_range(8'hF0, 8'hF7)));
                send_tails(3);
            end
            5: begin
                send_item(sld_pkg::OP_DATA, sld_pkg::CH_BSLASH);
                send_item(sld_pkg::OP_DATA, esc_set[$urandom_range(0, 10)]);
            end
            6: begin
                send_item(sld_pkg::OP_DATA, sld_pkg::CH_BSLASH);
                send_item(sld_pkg::OP_DATA, sld_pkg::CH_LC_U);
                send_hex(4);
            end
            7: begin
                send_item(sld_pkg::OP_DATA, sld_pkg::CH_BSLASH);
                send_item(sld_pkg::OP_DATA, sld_pkg::CH_UC_U);
                send_hex(8);
            end
            8: begin
                send_item(sld_pkg::OP_DATA, sld_pkg::CH_BSLASH);
                send_item(sld_pkg::OP_DATA, sld_pkg::CH_LC_X);
                send_hex($urandom_range(0, 4));
            end
            default: begin
                b = 8'($urandom_range(0, 127));
                if (b == sld_pkg::CH_BSLASH ||
                    (cur_mode == sld_pkg::MODE_STRING && b == sld_pkg::CH_DQUOTE)) b = CH_UC_A;
                send_item(sld_pkg::OP_DATA, b);
            end
        endcase
    endtask

    // Broken input: stray bytes, early ends, restarts, bad leads, tails and escapes
    task automatic send_noise();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: send_item(sld_pkg::OP_DATA, 8'($urandom));
            1: send_item(sld_pkg::OP_END, 8'($urandom));
            2: send_item(sld_pkg::OP_START, 8'($urandom));
            3: send_item(OP_NONE, 8'($urandom));
            4: begin
                send_item(sld_pkg::OP_DATA, sld_pkg::CH_BSLASH);
                send_item(sld_pkg::OP_DATA, 8'($urandom));
            end
            5: begin
                send_item(sld_pkg::OP_DATA, 8'($urandom_range(8'hF8, 8'hFF)));
                send_tails(3);
            end
            6: begin
                b = 8'($urandom);
                if (b[7:6] == 2'b10) b[6] = 1'b1;
                send_item(sld_pkg::OP_DATA, 8'($urandom_range(8'hC0, 8'hF7)));
                send_item(sld_pkg::OP_DATA, b);
            end
            default: begin
                send_item(sld_pkg::OP_DATA, sld_pkg::CH_BSLASH);
                send_item(sld_pkg::OP_DATA,
                          $urandom_range(0, 1) ? sld_pkg::CH_LC_U : sld_pkg::CH_UC_U);
                send_hex($urandom_range(0, 3));
                if ($urandom_range(0, 1)) send_item(sld_pkg::OP_DATA, 8'($urandom));
                else send_item(sld_pkg::OP_END, 8'($urandom));
            end
        endcase
    endtask

    // One literal, mostly well formed, sometimes broken or unterminated
    task automatic send_literal();
        bit broken;
        int n;
        broken = ($urandom_range(0, 5) == 0);
        send_item(sld_pkg::OP_START, 8'($urandom));
        n = (cur_mode == sld_pkg::MODE_CHAR) ? 1 : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            if (broken && $urandom_range(0, 2) == 0) send_noise();
            send_char();
        end
        if (broken && $urandom_range(0, 1)) begin
            send_noise();
        end else if (broken) begin
            send_item(sld_pkg::OP_END, 8'($urandom));
        end else begin
            send_item(sld_pkg::OP_DATA,
                      (cur_mode == sld_pkg::MODE_CHAR) ? sld_pkg::CH_SQUOTE : sld_pkg::CH_DQUOTE);
        end
        // stray beats between literals are ignored by the block
        if ($urandom_range(0, 9) == 0) send_item(sld_pkg::OP_DATA, 8'($urandom));
    endtask

    initial begin
        int target;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: string mode
        write_mode(sld_pkg::MODE_STRING);
        send_item(sld_pkg::OP_END, 8'h00);
        send_item(OP_NONE, 8'hFF);
        send_item(sld_pkg::OP_START, 8'h00);
        send_item(sld_pkg::OP_DATA, 8'h00);
        send_item(sld_pkg::OP_DATA, 8'hC3);
        send_item(sld_pkg::OP_DATA, 8'hA9);
        send_item(sld_pkg::OP_DATA, 8'hF4);
        send_item(sld_pkg::OP_DATA, 8'h8F);
        send_item(sld_pkg::OP_DATA, 8'hBF);
        send_item(sld_pkg::OP_DATA, 8'hBF);
        // \x41 closed by the quote: flushes the value, then closes
        send_item(sld_pkg::OP_DATA, sld_pkg::CH_BSLASH);
        send_item(sld_pkg::OP_DATA, sld_pkg::CH_LC_X);
        send_item(sld_pkg::OP_DATA, 8'h34);
        send_item(sld_pkg::OP_DATA, 8'h31);
        send_item(sld_pkg::OP_DATA, sld_pkg::CH_DQUOTE);
        // lead of 0xF8 or above fails after its three tails
        send_item(sld_pkg::OP_START, 8'hFF);
        send_item(sld_pkg::OP_DATA, 8'hFF);
        send_tails(3);

        // Directed: char mode
        write_mode(sld_pkg::MODE_CHAR);
        send_item(sld_pkg::OP_START, 8'h00);
        send_item(sld_pkg::OP_DATA, sld_pkg::CH_SQUOTE);
        send_item(sld_pkg::OP_DATA, sld_pkg::CH_SQUOTE);
        send_item(sld_pkg::OP_START, 8'h00);
        send_item(sld_pkg::OP_END, 8'h00);
        send_item(sld_pkg::OP_START, 8'h00);
        send_item(sld_pkg::OP_DATA, sld_pkg::CH_LC_A);
        send_item(sld_pkg::OP_DATA, sld_pkg::CH_LC_B);

        // Random phases alternating mode; the last one runs without idling
        target = items_sent;
        for (int p = 0; p < 4; p++) begin
            write_mode((p % 2 == 0) ? sld_pkg::MODE_STRING : sld_pkg::MODE_CHAR);
            target += PHASE_ITEMS;
            while (items_sent < target) begin
                idle_en = (p < 3) && ($urandom_range(0, 3) != 0);
                send_literal();
            end
        end

        idle_en = 1'b0;
        drain();
        repeat (10) @(negedge aclk);

        $display("Covered %0d input beats in both literal modes with stalls on both sides.",
                 items_sent);
        $display("Checked %0d code points, %0d closes, %0d errors; %0d mismatches.",
                 sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
